// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the step unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/dr_pkg.sv =====
// Types and constants of the dead-reckoning step unit.
package dr_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CW = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI     = 34'sd1073741824;
    localparam logic signed [CW-1:0] FULL_PI     = 34'sd2147483648;

    localparam logic [29:0] ATAN_TAB [32] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
        30'h00000001, 30'h00000000
    };

    localparam logic [32:0]          RADIUS_RESET = 33'd6371000000;
    localparam logic signed [27:0]   ALT_MIN      = -28'sd1000000;
    localparam logic signed [27:0]   ALT_MAX      = 28'sd100000000;
    localparam logic signed [24:0]   INV_PI_Q25   = 25'sd10680707;
    localparam logic [19:0]          USEC_PER_SEC = 20'd1000000;

    typedef struct packed {
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic signed [27:0] alt;
        logic signed [24:0] spd;
        logic [23:0]        dt;
    } dr_in_side_t;

    typedef struct packed {
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic signed [27:0] alt;
    } dr_pos_t;

    typedef struct packed {
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic signed [27:0] alt;
        logic               clip;
    } dr_res_t;

endpackage

// ===== rtl/dr_cordic.sv =====
// Pipelined rotation CORDIC giving sine and cosine of two angles side by side.
module dr_cordic #(
    parameter int STAGES = dr_pkg::CORDIC_STAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         ce,
    input  logic                         in_valid,
    input  logic [1:0][31:0]             angle,
    input  dr_pkg::dr_in_side_t          side_in,
    output logic                         out_valid,
    output logic [1:0][dr_pkg::CW-1:0]   sin_q,
    output logic [1:0][dr_pkg::CW-1:0]   cos_q,
    output dr_pkg::dr_in_side_t          side_out
);
    import dr_pkg::*;

    logic [STAGES+1:0]      vld_reg;
    logic signed [CW-1:0]   x_reg [STAGES+1][2];
    logic signed [CW-1:0]   y_reg [STAGES+1][2];
    logic signed [CW-1:0]   z_reg [STAGES+1][2];
    logic [1:0]             neg_reg [STAGES+1];
    dr_in_side_t            side_reg [STAGES+1];
    logic signed [CW-1:0]   z0_next [2];
    logic [1:0]             neg0_next;
    logic [1:0][CW-1:0]     sin_reg;
    logic [1:0][CW-1:0]     cos_reg;
    dr_in_side_t            side_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[STAGES:0], in_valid};
        end
    end

    // fold into [-pi/2, pi/2]
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            z0_next[l]   = CW'($signed(angle[l]));
            neg0_next[l] = 1'b0;
            if (z0_next[l] > HALF_PI)
            begin
                z0_next[l]   = z0_next[l] - FULL_PI;
                neg0_next[l] = 1'b1;
            end
            else if (z0_next[l] < -HALF_PI)
            begin
                z0_next[l]   = z0_next[l] + FULL_PI;
                neg0_next[l] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int l = 0; l < 2; l++)
            begin
                x_reg[0][l] <= CORDIC_GAIN;
                y_reg[0][l] <= '0;
                z_reg[0][l] <= z0_next[l];
            end
            neg_reg[0]  <= neg0_next;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        localparam int K = i % 32;
        localparam logic signed [CW-1:0] ATAN_Z = signed'({{(CW-30){1'b0}}, ATAN_TAB[K]});

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    if (z_reg[i][l] >= 0)
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] - (y_reg[i][l] >>> K);
                        y_reg[i+1][l] <= y_reg[i][l] + (x_reg[i][l] >>> K);
                        z_reg[i+1][l] <= z_reg[i][l] - ATAN_Z;
                    end
                    else
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] + (y_reg[i][l] >>> K);
                        y_reg[i+1][l] <= y_reg[i][l] - (x_reg[i][l] >>> K);
                        z_reg[i+1][l] <= z_reg[i][l] + ATAN_Z;
                    end
                end
                neg_reg[i+1]  <= neg_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int l = 0; l < 2; l++)
            begin
                sin_reg[l] <= neg_reg[STAGES][l] ? -y_reg[STAGES][l] : y_reg[STAGES][l];
                cos_reg[l] <= neg_reg[STAGES][l] ? -x_reg[STAGES][l] : x_reg[STAGES][l];
            end
            side_out_reg <= side_reg[STAGES];
        end
    end

    assign out_valid = vld_reg[STAGES+1];
    assign sin_q     = sin_reg;
    assign cos_q     = cos_reg;
    assign side_out  = side_out_reg;

endmodule

// ===== rtl/dr_div.sv =====
// Pipelined restoring divider with round-half-away-from-zero, lanes share one divisor.
module dr_div #(
    parameter int LANES = 2,
    parameter int NW    = 63,
    parameter int DW    = 36,
    parameter int QW    = 32,
    parameter int SW    = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NW-1:0]    num,
    input  logic [DW-1:0]               divisor,
    input  logic [SW-1:0]               side_in,
    output logic                        out_valid,
    output logic [LANES-1:0][QW-1:0]    quo,
    output logic [SW-1:0]               side_out
);
    localparam int UW = NW + 1;

    logic [UW+1:0]              vld_reg;
    logic [UW-1:0]              num_reg [UW+1][LANES];
    logic [DW-1:0]              rem_reg [UW+1][LANES];
    logic [QW-1:0]              q_reg   [UW+1][LANES];
    logic [LANES-1:0]           neg_reg [UW+1];
    logic [DW-1:0]              d_reg   [UW+1];
    logic [SW-1:0]              side_reg [UW+1];
    logic [DW:0]                trial   [UW][LANES];
    logic                       take    [UW][LANES];
    logic [NW-1:0]              mag     [LANES];
    logic [LANES-1:0]           sgn;
    logic [LANES-1:0][QW-1:0]   quo_reg;
    logic [SW-1:0]              side_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[UW:0], in_valid};
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sgn[l] = num[l][NW-1];
            mag[l] = sgn[l] ? (~num[l] + NW'(1)) : num[l];
        end
    end

    // magnitude plus half the divisor
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                num_reg[0][l] <= UW'(mag[l]) + UW'(divisor >> 1);
                rem_reg[0][l] <= '0;
                q_reg[0][l]   <= '0;
            end
            neg_reg[0]  <= sgn;
            d_reg[0]    <= divisor;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < UW; i++)
    begin : g_step
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            assign trial[i][l] = {rem_reg[i][l], num_reg[i][l][UW-1]};
            assign take[i][l]  = trial[i][l] >= {1'b0, d_reg[i]};
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[i+1][l] <= take[i][l] ? DW'(trial[i][l] - {1'b0, d_reg[i]})
                                                  : trial[i][l][DW-1:0];
                    num_reg[i+1][l] <= num_reg[i][l] << 1;
                    q_reg[i+1][l]   <= {q_reg[i][l][QW-2:0], take[i][l]};
                end
                neg_reg[i+1]  <= neg_reg[i];
                d_reg[i+1]    <= d_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                quo_reg[l] <= neg_reg[UW][l] ? (~q_reg[UW][l] + QW'(1)) : q_reg[UW][l];
            end
            side_out_reg <= side_reg[UW];
        end
    end

    assign out_valid = vld_reg[UW+1];
    assign quo       = quo_reg;
    assign side_out  = side_out_reg;

endmodule

// ===== rtl/dead_reckoning_step_unit.sv =====
// Dead-reckoning step on a sphere: one position update per word, fully pipelined.
// One input word is accepted every clock cycle while the output is free or being taken;
// a stall at the output holds the whole pipeline. The pipeline consists of the CORDIC pipeline
// with its fold and output stages, five multiply stages, five stages of reciprocal
// multiplication for the division by one million, one scaling stage, a 66-stage divider for
// the division by four times (altitude + earth radius) and the output stage. The radius
// register may only be written while the pipeline is empty.
`include "assert_macros.svh"

module dead_reckoning_step_unit #(
    parameter int CORDIC_STAGES = dr_pkg::CORDIC_STAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // latitude_in[31:0], longitude_in[63:32], altitude_in[91:64], speed[116:92],
    // time_step[140:117], pitch[172:141], bearing[204:173], zero[207:205]
    input  logic [207:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // latitude_out[31:0], longitude_out[63:32], altitude_out[91:64],
    // altitude_clipped[92], zero[95:93]
    output logic [95:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_wr_en,
    input  logic [32:0]  cfg_wr_data
);
    import dr_pkg::*;

    localparam int NW1 = 59;
    localparam int QW1 = 38;
    localparam int NW2 = 63;
    localparam int DW2 = 36;
    localparam int QW2 = 32;

    // ceil(2^65 / 15625): one million is 64 * 15625
    localparam logic [51:0] USEC_RECIP = 52'd2361183241434823;

    logic                    adv;
    logic [32:0]             radius_reg;
    dr_in_side_t             in_side;
    logic [1:0][31:0]        in_angle;

    logic                    cor_vld;
    logic [1:0][CW-1:0]      cor_sin;
    logic [1:0][CW-1:0]      cor_cos;
    dr_in_side_t             cor_side;
    dr_pos_t                 cor_pos;

    logic                    a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg;
    logic                    t1_vld_reg, t2_vld_reg, t3_vld_reg, t4_vld_reg, t5_vld_reg;
    logic                    f_vld_reg, out_vld_reg;

    logic signed [58:0]      a_p1_next, a_p2_next, a_p1_reg, a_p2_reg;
    logic signed [CW-1:0]    a_sb_reg, a_cb_reg;
    dr_pos_t                 a_pos_reg;
    logic [23:0]             a_dt_reg;

    logic signed [CW-1:0]    b_h_reg, b_vu_reg, b_sb_reg, b_cb_reg;
    dr_pos_t                 b_pos_reg;
    logic [23:0]             b_dt_reg;

    logic signed [67:0]      c_pn_next, c_pe_next, c_pn_reg, c_pe_reg;
    logic signed [CW-1:0]    c_vu_reg;
    dr_pos_t                 c_pos_reg;
    logic [23:0]             c_dt_reg;

    logic signed [CW-1:0]    d_vn_reg, d_ve_reg, d_vu_reg;
    dr_pos_t                 d_pos_reg;
    logic [23:0]             d_dt_reg;

    logic signed [NW1-1:0]   e_qn_next, e_qe_next, e_qu_next;
    logic [2:0][NW1-1:0]     e_q_reg;
    dr_pos_t                 e_pos_reg;

    logic [NW1-1:0]          t1_sum [3];
    logic [50:0]             t1_a_reg [3];
    logic [2:0]              t1_neg_reg, t2_neg_reg, t3_neg_reg, t4_neg_reg;
    logic [51:0]             t2_p00_reg [3];
    logic [51:0]             t2_p01_reg [3];
    logic [50:0]             t2_p10_reg [3];
    logic [50:0]             t2_p11_reg [3];
    logic [79:0]             t3_s_reg [3];
    logic [50:0]             t3_p11_reg [3];
    logic [102:0]            t4_total [3];
    logic [QW1-1:0]          t4_q_reg [3];
    logic [2:0][QW1-1:0]     t5_q_reg;
    dr_pos_t                 t1_pos_reg, t2_pos_reg, t3_pos_reg, t4_pos_reg, t5_pos_reg;

    logic                    q1_vld;
    logic [2:0][QW1-1:0]     q1;
    dr_pos_t                 q1_pos;

    logic signed [NW2-1:0]   f_mn_next, f_me_next;
    logic [1:0][NW2-1:0]     f_m_reg;
    logic signed [29:0]      f_dalt;
    logic signed [31:0]      f_sum;
    logic signed [34:0]      f_den_sum;
    logic [33:0]             f_den;
    logic [DW2-1:0]          f_d4_reg;
    dr_res_t                 f_res_next, f_res_reg;

    logic                    q2_vld;
    logic [1:0][QW2-1:0]     q2;
    dr_res_t                 q2_res;

    logic [31:0]             out_lat_reg, out_lon_reg;
    logic [27:0]             out_alt_reg;
    logic                    out_clip_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            radius_reg <= cfg_wr_data;
        end
    end

    assign in_side.lat = s_tdata[31:0];
    assign in_side.lon = s_tdata[63:32];
    assign in_side.alt = s_tdata[91:64];
    assign in_side.spd = s_tdata[116:92];
    assign in_side.dt  = s_tdata[140:117];
    assign in_angle[0] = s_tdata[172:141];
    assign in_angle[1] = s_tdata[204:173];

    dr_cordic #(
        .STAGES    (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (adv),
        .in_valid  (s_tvalid),
        .angle     (in_angle),
        .side_in   (in_side),
        .out_valid (cor_vld),
        .sin_q     (cor_sin),
        .cos_q     (cor_cos),
        .side_out  (cor_side)
    );

    assign cor_pos.lat = cor_side.lat;
    assign cor_pos.lon = cor_side.lon;
    assign cor_pos.alt = cor_side.alt;

    assign a_p1_next = cor_side.spd * $signed(cor_cos[0]);
    assign a_p2_next = cor_side.spd * $signed(cor_sin[0]);
    assign c_pn_next = b_h_reg * b_cb_reg;
    assign c_pe_next = b_h_reg * b_sb_reg;
    assign e_qn_next = d_vn_reg * $signed({1'b0, d_dt_reg});
    assign e_qe_next = d_ve_reg * $signed({1'b0, d_dt_reg});
    assign e_qu_next = d_vu_reg * $signed({1'b0, d_dt_reg});

    // magnitude plus half a million, then the full reciprocal product
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            t1_sum[l]   = (e_q_reg[l][NW1-1] ? (~e_q_reg[l] + NW1'(1)) : e_q_reg[l])
                          + NW1'(USEC_PER_SEC >> 1);
            t4_total[l] = 103'(t3_s_reg[l]) + {t3_p11_reg[l], 52'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            t1_vld_reg  <= 1'b0;
            t2_vld_reg  <= 1'b0;
            t3_vld_reg  <= 1'b0;
            t4_vld_reg  <= 1'b0;
            t5_vld_reg  <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg   <= cor_vld;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            t1_vld_reg  <= e_vld_reg;
            t2_vld_reg  <= t1_vld_reg;
            t3_vld_reg  <= t2_vld_reg;
            t4_vld_reg  <= t3_vld_reg;
            t5_vld_reg  <= t4_vld_reg;
            f_vld_reg   <= q1_vld;
            out_vld_reg <= q2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_p1_reg  <= a_p1_next;
            a_p2_reg  <= a_p2_next;
            a_sb_reg  <= $signed(cor_sin[1]);
            a_cb_reg  <= $signed(cor_cos[1]);
            a_pos_reg <= cor_pos;
            a_dt_reg  <= cor_side.dt;

            b_h_reg   <= CW'((a_p1_reg + 59'sd2097152) >>> 22);
            b_vu_reg  <= CW'((a_p2_reg + 59'sd2097152) >>> 22);
            b_sb_reg  <= a_sb_reg;
            b_cb_reg  <= a_cb_reg;
            b_pos_reg <= a_pos_reg;
            b_dt_reg  <= a_dt_reg;

            c_pn_reg  <= c_pn_next;
            c_pe_reg  <= c_pe_next;
            c_vu_reg  <= b_vu_reg;
            c_pos_reg <= b_pos_reg;
            c_dt_reg  <= b_dt_reg;

            d_vn_reg  <= CW'((c_pn_reg + 68'sd536870912) >>> 30);
            d_ve_reg  <= CW'((c_pe_reg + 68'sd536870912) >>> 30);
            d_vu_reg  <= c_vu_reg;
            d_pos_reg <= c_pos_reg;
            d_dt_reg  <= c_dt_reg;

            e_q_reg[0] <= e_qn_next;
            e_q_reg[1] <= e_qe_next;
            e_q_reg[2] <= e_qu_next;
            e_pos_reg  <= d_pos_reg;

            // divide by 64, then by 15625 through the reciprocal in 26-bit halves
            for (int l = 0; l < 3; l++)
            begin
                t1_a_reg[l]   <= t1_sum[l][56:6];
                t1_neg_reg[l] <= e_q_reg[l][NW1-1];

                t2_p00_reg[l] <= t1_a_reg[l][25:0] * USEC_RECIP[25:0];
                t2_p01_reg[l] <= t1_a_reg[l][25:0] * USEC_RECIP[51:26];
                t2_p10_reg[l] <= t1_a_reg[l][50:26] * USEC_RECIP[25:0];
                t2_p11_reg[l] <= t1_a_reg[l][50:26] * USEC_RECIP[51:26];

                t3_s_reg[l]   <= 80'(t2_p00_reg[l])
                                 + ((80'(t2_p01_reg[l]) + 80'(t2_p10_reg[l])) << 26);
                t3_p11_reg[l] <= t2_p11_reg[l];

                t4_q_reg[l]   <= t4_total[l][102:65];

                t5_q_reg[l]   <= t4_neg_reg[l] ? (~t4_q_reg[l] + QW1'(1)) : t4_q_reg[l];
            end
            t2_neg_reg <= t1_neg_reg;
            t3_neg_reg <= t2_neg_reg;
            t4_neg_reg <= t3_neg_reg;
            t1_pos_reg <= e_pos_reg;
            t2_pos_reg <= t1_pos_reg;
            t3_pos_reg <= t2_pos_reg;
            t4_pos_reg <= t3_pos_reg;
            t5_pos_reg <= t4_pos_reg;
        end
    end

    assign q1_vld = t5_vld_reg;
    assign q1     = t5_q_reg;
    assign q1_pos = t5_pos_reg;

    assign f_mn_next = $signed(q1[0]) * INV_PI_Q25;
    assign f_me_next = $signed(q1[1]) * INV_PI_Q25;
    assign f_dalt    = 30'(($signed(q1[2]) + 38'sd128) >>> 8);
    assign f_sum     = 32'(q1_pos.alt) + 32'(f_dalt);
    assign f_den_sum = $signed({2'b00, radius_reg}) + 35'(q1_pos.alt);
    assign f_den     = (f_den_sum < 35'sd1) ? 34'd1 : f_den_sum[33:0];

    always_comb
    begin
        f_res_next.lat  = q1_pos.lat;
        f_res_next.lon  = q1_pos.lon;
        f_res_next.alt  = f_sum[27:0];
        f_res_next.clip = 1'b0;
        priority if (f_sum > 32'(ALT_MAX))
        begin
            f_res_next.alt  = ALT_MAX;
            f_res_next.clip = 1'b1;
        end
        else if (f_sum < 32'(ALT_MIN))
        begin
            f_res_next.alt  = ALT_MIN;
            f_res_next.clip = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_m_reg[0] <= f_mn_next;
            f_m_reg[1] <= f_me_next;
            f_d4_reg   <= {f_den, 2'b00};
            f_res_reg  <= f_res_next;
        end
    end

    dr_div #(
        .LANES     (2),
        .NW        (NW2),
        .DW        (DW2),
        .QW        (QW2),
        .SW        ($bits(dr_res_t))
    ) u_div_radius (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (adv),
        .in_valid  (f_vld_reg),
        .num       (f_m_reg),
        .divisor   (f_d4_reg),
        .side_in   (f_res_reg),
        .out_valid (q2_vld),
        .quo       (q2),
        .side_out  (q2_res)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_lat_reg  <= q2_res.lat + q2[0];
            out_lon_reg  <= q2_res.lon + q2[1];
            out_alt_reg  <= q2_res.alt;
            out_clip_reg <= q2_res.clip;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_clip_reg, out_alt_reg, out_lon_reg, out_lat_reg};

    `ASSERT_CLK(a_clip_sat, clk, rst_n, m_tvalid && m_tdata[92] |-> $signed(m_tdata[91:64]) == ALT_MIN || $signed(m_tdata[91:64]) == ALT_MAX, "clipped altitude not at a limit")
    `ASSERT_CLK(a_alt_range, clk, rst_n, m_tvalid |-> $signed(m_tdata[91:64]) >= ALT_MIN && $signed(m_tdata[91:64]) <= ALT_MAX, "altitude out of range")
    `ASSERT_CLK(a_ready_free, clk, rst_n, !m_tvalid |-> s_tready, "input held while output empty")
    `ASSERT_NEVER(a_stall_hold, clk, rst_n, m_tvalid && !m_tready && s_tready, "input taken during output stall")

endmodule

// ===== dv/dead_reckoning_checker.sv =====
// Checker for the dead-reckoning step unit: watches both streams, predicts and compares.
`timescale 1ns / 100ps

module dead_reckoning_checker #(
    parameter int CORDIC_STAGES = dr_pkg::CORDIC_STAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [207:0] s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  m_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_wr_en,
    input  logic [32:0]  cfg_wr_data,
    output int           pending,
    output int           failures
);
    import dr_pkg::*;

    localparam longint MICROS_PER_SEC = 64'sd1000000;
    localparam longint INV_PI         = 64'sd10680707;

    logic [32:0] radius_mm;
    dr_res_t     expected_pos_q[$];

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint round_div(input longint n, input longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic void sin_cos(input longint ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint t;
        bit     flip;
        int     k;
        x    = longint'(CORDIC_GAIN);
        y    = 0;
        z    = ang;
        flip = 1'b0;
        if (z > (64'sd1 <<< 30))
        begin
            z    = z - (64'sd1 <<< 31);
            flip = 1'b1;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z    = z + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            k = i % 32;
            if (z >= 0)
            begin
                t = x - (y >>> k);
                y = y + (x >>> k);
                z = z - longint'(ATAN_TAB[k]);
            end
            else
            begin
                t = x + (y >>> k);
                y = y - (x >>> k);
                z = z + longint'(ATAN_TAB[k]);
            end
            x = t;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic dr_res_t next_position(input logic [207:0] w, input logic [32:0] rad);
        dr_res_t r;
        longint  lat, lon, alt, spd, dt;
        longint  sp, cp, sb, cb, h, vn, ve, vu, dn, de, du, den, nalt;
        lat = longint'($signed(w[31:0]));
        lon = longint'($signed(w[63:32]));
        alt = longint'($signed(w[91:64]));
        spd = longint'($signed(w[116:92]));
        dt  = longint'({40'd0, w[140:117]});
        sin_cos(longint'($signed(w[172:141])), sp, cp);
        sin_cos(longint'($signed(w[204:173])), sb, cb);
        h   = round_shift(spd * cp, 22);
        vn  = round_shift(h * cb, 30);
        ve  = round_shift(h * sb, 30);
        vu  = round_shift(spd * sp, 22);
        dn  = round_div(vn * dt, MICROS_PER_SEC);
        de  = round_div(ve * dt, MICROS_PER_SEC);
        du  = round_div(vu * dt, MICROS_PER_SEC);
        den = longint'({31'd0, rad}) + alt;
        if (den < 1)
            den = 1;
        r.lat  = 32'(lat + round_div(dn * INV_PI, 4 * den));
        r.lon  = 32'(lon + round_div(de * INV_PI, 4 * den));
        nalt   = alt + round_shift(du, 8);
        r.clip = 1'b0;
        if (nalt > longint'(ALT_MAX))
        begin
            nalt   = longint'(ALT_MAX);
            r.clip = 1'b1;
        end
        else if (nalt < longint'(ALT_MIN))
        begin
            nalt   = longint'(ALT_MIN);
            r.clip = 1'b1;
        end
        r.alt = 28'(nalt);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dr_res_t exp_r;
        dr_res_t got;
        if (!rst_n)
        begin
            radius_mm = RADIUS_RESET;
            expected_pos_q.delete();
            pending  <= 0;
            failures <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.lat  = m_tdata[31:0];
                got.lon  = m_tdata[63:32];
                got.alt  = m_tdata[91:64];
                got.clip = m_tdata[92];
                if (expected_pos_q.size() == 0)
                begin
                    $error("unexpected output word %h", m_tdata);
                    failures <= failures + 1;
                end
                else
                begin
                    exp_r = expected_pos_q.pop_front();
                    if (got.lat !== exp_r.lat)
                        $error("latitude_out: expected %0d, got %0d", exp_r.lat, got.lat);
                    if (got.lon !== exp_r.lon)
                        $error("longitude_out: expected %0d, got %0d", exp_r.lon, got.lon);
                    if (got.alt !== exp_r.alt)
                        $error("altitude_out: expected %0d, got %0d", exp_r.alt, got.alt);
                    if (got.clip !== exp_r.clip)
                        $error("altitude_clipped: expected %0d, got %0d", exp_r.clip,
                               got.clip);
                    if (got !== exp_r)
                        failures <= failures + 1;
                end
            end
            if (s_tvalid && s_tready)
                expected_pos_q.push_back(next_position(s_tdata, radius_mm));
            if (cfg_wr_en)
                radius_mm = cfg_wr_data;
            pending <= expected_pos_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Testbench top for the dead-reckoning step unit: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
    import dr_pkg::*;

    localparam int LATENCY     = CORDIC_STAGES_DEF + 80;
    localparam int DRAIN_WAIT  = LATENCY + 40;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_WORDS = 325;

    logic         clk;
    logic         rst_n;
    logic [207:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_wr_en;
    logic [32:0]  cfg_wr_data;
    int           pending;
    int           failures;
    int           send_idle;
    int           recv_idle;
    int           quiet_cycles;

    dead_reckoning_step_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    dead_reckoning_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .pending    (pending),
        .failures   (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [207:0] pack_word(input logic [31:0] lat, input logic [31:0] lon,
                                               input logic [27:0] alt, input logic [24:0] spd,
                                               input logic [23:0] dt, input logic [31:0] pitch,
                                               input logic [31:0] brg);
        return {3'b000, brg, pitch, dt, spd, alt, lon, lat};
    endfunction

    function automatic logic [207:0] random_word();
        logic [27:0] alt;
        logic [24:0] spd;
        logic [23:0] dt;
        int          pick;
        pick = $urandom_range(9);
        if (pick < 6)
            alt = 28'($urandom_range(101000000) - 1000000);
        else if (pick < 8)
            alt = (pick == 6) ? 28'(ALT_MAX - $urandom_range(500000))
                              : 28'(ALT_MIN + $urandom_range(500000));
        else
            alt = 28'($urandom);
        pick = $urandom_range(9);
        spd  = (pick < 8) ? 25'($urandom_range(20000000) - 10000000) : 25'($urandom);
        pick = $urandom_range(9);
        if (pick < 5)
            dt = 24'($urandom_range(10000000));
        else if (pick < 8)
            dt = 24'($urandom_range(2000));
        else
            dt = 24'($urandom);
        return pack_word($urandom, $urandom, alt, spd, dt, $urandom, $urandom);
    endfunction

    task automatic send_word(input logic [207:0] w);
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_radius(input logic [32:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    logic [32:0] radius_plan [6];

    initial
    begin
        rst_n       = 1'b0;
        s_tdata     = '0;
        s_tvalid    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        send_idle   = 0;
        recv_idle   = 0;
        radius_plan = '{33'd1000000000, 33'd8000000000, 33'h1_FFFF_FFFF, 33'd0,
                        33'd3000000000, RADIUS_RESET};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, fold boundaries, pole crossing, clipping
        send_word(pack_word(0, 0, 0, 0, 0, 0, 0));
        send_word(pack_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 28'(ALT_MAX), 25'sd10000000,
                            24'd10000000, 0, 0));
        send_word(pack_word(32'h8000_0000, 32'h8000_0000, 28'(ALT_MIN), -25'sd10000000,
                            24'd10000000, 0, 32'h4000_0000));
        send_word(pack_word(32'h4000_0000, 0, 0, 25'sd10000000, 24'hFF_FFFF, 0, 0));
        send_word(pack_word(32'hC000_0000, 0, 0, -25'sd10000000, 24'hFF_FFFF, 0, 0));
        send_word(pack_word(0, 32'h7FFF_0000, 0, 25'sd10000000, 24'hFF_FFFF, 0, 32'h4000_0000));
        send_word(pack_word(0, 0, 28'(ALT_MAX - 10), 25'sd10000000, 24'd10000000,
                            32'h4000_0000, 0));
        send_word(pack_word(0, 0, 28'(ALT_MIN + 10), 25'sd10000000, 24'd10000000,
                            32'hC000_0000, 0));
        send_word(pack_word(0, 0, 28'h7FF_FFFF, 0, 0, 0, 0));
        send_word(pack_word(0, 0, 28'h800_0000, 0, 0, 0, 0));
        send_word(pack_word(0, 0, 0, 25'h0FF_FFFF, 24'hFF_FFFF, 32'h4000_0001, 32'h4000_0001));
        send_word(pack_word(0, 0, 0, 25'h100_0000, 24'hFF_FFFF, 32'hBFFF_FFFF, 32'hBFFF_FFFF));
        send_word(pack_word(0, 0, 0, 25'sd5000000, 24'd1000000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_word(pack_word(0, 0, 0, 25'sd5000000, 24'd1000000, 32'h8000_0000, 32'h7FFF_FFFF));
        send_word(pack_word(0, 0, 0, 25'sd5000000, 24'd1000000, 32'h2000_0000, 32'hE000_0000));
        send_word(pack_word(32'h1234_5678, 32'h9ABC_DEF0, 28'sd500000, -25'sd1, 24'd1,
                            32'h0000_0001, 32'hFFFF_FFFF));
        send_word(pack_word(0, 0, 0, 25'sd1, 24'd1, 0, 0));

        // below-range radius: the radius sum falls to one or less
        write_radius(33'd0);
        send_word(pack_word(0, 0, -28'sd1000000, 25'sd10000000, 24'd10000000, 0,
                            32'h2000_0000));
        send_word(pack_word(0, 0, 0, 25'sd10000000, 24'd10000000, 0, 32'hE000_0000));

        for (int p = 0; p < 6; p++)
        begin
            write_radius(radius_plan[p]);
            case (p / 2)
                0:
                begin
                    send_idle = 12;
                    recv_idle = 74;
                end
                1:
                begin
                    send_idle = 74;
                    recv_idle = 12;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(random_word());
        end

        drain();
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
